// ===== src/gsma_pkg.sv =====
package gsma_pkg;

   localparam int MAX_ROWS = 16;
   localparam int MAX_COLS = 16;
   localparam int ROW_W = 4;
   localparam int COL_W = 4;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int COST_W = 16;
   localparam int SUM_W = 21;
   localparam int GID_W = 5;
   localparam int SIZE_W = 5;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ONE  = 2'd1;
   localparam logic [1:0] KIND_MROW = 2'd2;
   localparam logic [1:0] KIND_MCOL = 2'd3;

   localparam logic [1:0] REC_ROW   = 2'd0;
   localparam logic [1:0] REC_COL   = 2'd1;
   localparam logic [1:0] REC_TOTAL = 2'd2;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic          clear;      // start of walk: clear owners and totals
      logic          scan_start; // reset running best
      logic          scan_step;  // compare entry at scan address
      logic [ADDR_W-1:0] scan_addr;
      logic          commit;     // apply best entry
      logic [1:0]    emit_kind;
      logic [ROW_W-1:0] emit_idx;
      logic          emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic found;
   } sts_type;

endpackage

// ===== src/greedy_star_multi_assignment.sv =====
// Greedy star multi-assignment over a cost matrix of signed Q8.8 entries.
// Input: pulse start with req_row_index, req_col_index, req_entry_cost and
// req_final_entry while busy is low; each accepted beat stores one entry.
// A beat with req_final_entry set stores its entry, then runs the walk.
// Walk: the clear state, then rows*cols+1 passes; each pass is a full scan
// of the active rows x cols entries (one read per cycle from the cost memory)
// plus the drain and commit states that close it. busy is high through the
// walk and the output phase.
// Output: rows+cols+1 records, one per cycle with rsp_valid high for one
// cycle each: row mappings, column mappings, then the totals record with
// rsp_run_end set. The receiver cannot stall; records are simply strobed.
// Plain beats (no final flag) store their entry and produce nothing.
// Configuration: csr_valid/csr_ready write rows_in_use (index 0) and
// cols_in_use (index 1); csr_ready is always high. Write only while idle.
// Reset (synchronous, high) returns sizes to 16 and clears group state;
// stored costs are kept and are undefined until written.
module greedy_star_multi_assignment (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [3:0] req_row_index,
   input  logic [3:0] req_col_index,
   input  logic signed [15:0] req_entry_cost,
   input  logic req_final_entry,
   output logic rsp_valid,
   output logic [1:0] rsp_record_kind,
   output logic [3:0] rsp_map_index,
   output logic [4:0] rsp_group_id,
   output logic signed [20:0] rsp_total_cost,
   output logic [4:0] rsp_group_count,
   output logic rsp_run_end,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [4:0] csr_data
);
   gsma_pkg::cmd_type cmd;
   gsma_pkg::sts_type sts;
   logic [4:0] rows_ff, cols_ff;
   logic accept;

   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 5'd16;
         cols_ff <= 5'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            gsma_pkg::CSR_ROWS: rows_ff <= csr_data;
            gsma_pkg::CSR_COLS: cols_ff <= csr_data;
         endcase
      end
   end

   gsma_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(accept), .final_in(req_final_entry),
      .rows_ff(rows_ff), .cols_ff(cols_ff), .sts(sts), .cmd(cmd), .busy(busy)
   );

   gsma_datapath u_dp (
      .clock(clock), .reset(reset), .wr_en(accept),
      .wr_addr({req_row_index, req_col_index}), .wr_data(req_entry_cost),
      .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid),
      .rsp_record_kind(rsp_record_kind), .rsp_map_index(rsp_map_index),
      .rsp_group_id(rsp_group_id), .rsp_total_cost(rsp_total_cost),
      .rsp_group_count(rsp_group_count), .rsp_run_end(rsp_run_end)
   );
endmodule

// ===== src/gsma_datapath.sv =====
module gsma_datapath (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic [gsma_pkg::ADDR_W-1:0] wr_addr,
   input  logic signed [gsma_pkg::COST_W-1:0] wr_data,
   input  gsma_pkg::cmd_type cmd,
   output gsma_pkg::sts_type sts,
   output logic rsp_valid,
   output logic [1:0] rsp_record_kind,
   output logic [gsma_pkg::ROW_W-1:0] rsp_map_index,
   output logic [gsma_pkg::GID_W-1:0] rsp_group_id,
   output logic signed [gsma_pkg::SUM_W-1:0] rsp_total_cost,
   output logic [gsma_pkg::GID_W-1:0] rsp_group_count,
   output logic rsp_run_end
);
   localparam int AW = gsma_pkg::ADDR_W;
   localparam int RW = gsma_pkg::ROW_W;
   localparam int GW = gsma_pkg::GID_W;

   logic signed [gsma_pkg::COST_W-1:0] mem [gsma_pkg::DEPTH];
   logic signed [gsma_pkg::COST_W-1:0] rd_ff;
   logic [AW-1:0] rd_addr_ff;
   logic rd_valid_ff;

   logic [GW-1:0] row_owner_ff [gsma_pkg::MAX_ROWS];
   logic [GW-1:0] col_owner_ff [gsma_pkg::MAX_COLS];
   logic [1:0] kind_ff [16];
   logic signed [gsma_pkg::SUM_W-1:0] sum_ff;
   logic [GW-1:0] made_ff;

   logic found_ff;
   logic signed [gsma_pkg::COST_W-1:0] best_ff;
   logic [AW-1:0] best_addr_ff;

   logic have_prev_ff;
   logic signed [gsma_pkg::COST_W-1:0] prev_cost_ff;
   logic [AW-1:0] prev_addr_ff;
   logic below_prev;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[cmd.scan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step;
      end
      rd_addr_ff <= cmd.scan_addr;
   end

   // entries already visited rank above the last committed one; skip them
   assign below_prev = !have_prev_ff || rd_ff < prev_cost_ff
      || (rd_ff == prev_cost_ff && rd_addr_ff < prev_addr_ff);

   // running best over one scan; later entries win ties (scan ascends)
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         found_ff <= 1'b0;
      end else if (rd_valid_ff && below_prev && (!found_ff || rd_ff >= best_ff)) begin
         found_ff <= 1'b1;
         best_ff <= rd_ff;
         best_addr_ff <= rd_addr_ff;
      end
   end
   assign sts.found = found_ff;

   logic [RW-1:0] br, bc;
   logic [GW-1:0] gr, gc;
   assign br = best_addr_ff[AW-1 -: RW];
   assign bc = best_addr_ff[RW-1:0];
   assign gr = row_owner_ff[br];
   assign gc = col_owner_ff[bc];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         have_prev_ff <= 1'b0;
         sum_ff <= '0;
         made_ff <= '0;
         for (int i = 0; i < gsma_pkg::MAX_ROWS; i++) row_owner_ff[i] <= '0;
         for (int i = 0; i < gsma_pkg::MAX_COLS; i++) col_owner_ff[i] <= '0;
         for (int i = 0; i < 16; i++) kind_ff[i] <= gsma_pkg::KIND_NONE;
      end else if (cmd.commit) begin
         have_prev_ff <= 1'b1;
         prev_cost_ff <= best_ff;
         prev_addr_ff <= best_addr_ff;
         if (gr != '0 && gc == '0) begin
            if (kind_ff[gr[3:0]] == gsma_pkg::KIND_ONE
                  || kind_ff[gr[3:0]] == gsma_pkg::KIND_MCOL) begin
               kind_ff[gr[3:0]] <= gsma_pkg::KIND_MCOL;
               col_owner_ff[bc] <= gr;
               sum_ff <= sum_ff + gsma_pkg::SUM_W'(best_ff);
            end
         end else if (gr == '0 && gc != '0) begin
            if (kind_ff[gc[3:0]] == gsma_pkg::KIND_ONE
                  || kind_ff[gc[3:0]] == gsma_pkg::KIND_MROW) begin
               kind_ff[gc[3:0]] <= gsma_pkg::KIND_MROW;
               row_owner_ff[br] <= gc;
               sum_ff <= sum_ff + gsma_pkg::SUM_W'(best_ff);
            end
         end else if (gr == '0 && gc == '0) begin
            // group 16 lands in slot 0, which no other group uses
            made_ff <= made_ff + 1'b1;
            kind_ff[4'(made_ff + 1'b1)] <= gsma_pkg::KIND_ONE;
            row_owner_ff[br] <= made_ff + 1'b1;
            col_owner_ff[bc] <= made_ff + 1'b1;
            sum_ff <= sum_ff + gsma_pkg::SUM_W'(best_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
      rsp_record_kind <= cmd.emit_kind;
      unique case (cmd.emit_kind)
         gsma_pkg::REC_ROW: begin
            rsp_map_index <= cmd.emit_idx;
            rsp_group_id <= row_owner_ff[cmd.emit_idx];
            rsp_total_cost <= '0;
            rsp_group_count <= '0;
            rsp_run_end <= 1'b0;
         end
         gsma_pkg::REC_COL: begin
            rsp_map_index <= cmd.emit_idx;
            rsp_group_id <= col_owner_ff[cmd.emit_idx];
            rsp_total_cost <= '0;
            rsp_group_count <= '0;
            rsp_run_end <= 1'b0;
         end
         default: begin
            rsp_map_index <= '0;
            rsp_group_id <= '0;
            rsp_total_cost <= sum_ff;
            rsp_group_count <= made_ff;
            rsp_run_end <= 1'b1;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) cmd.commit |-> found_ff)
      else $error("commit without a candidate");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> have_prev_ff && prev_addr_ff == $past(best_addr_ff))
      else $error("committed entry not recorded");
   assert property (@(posedge clock) disable iff (reset) made_ff <= 5'd16)
      else $error("group count overflow");
endmodule

// ===== src/gsma_ctrl.sv =====
module gsma_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic final_in,
   input  logic [gsma_pkg::SIZE_W-1:0] rows_ff,
   input  logic [gsma_pkg::SIZE_W-1:0] cols_ff,
   input  gsma_pkg::sts_type sts,
   output gsma_pkg::cmd_type cmd,
   output logic busy
);
   localparam int RW = gsma_pkg::ROW_W;
   localparam logic [2:0] S_IDLE = 3'd0, S_CLEAR = 3'd1, S_SCAN = 3'd2,
      S_DRAIN = 3'd3, S_COMMIT = 3'd4, S_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [RW-1:0] r_ff, r_in, c_ff, c_in;
   logic [1:0] drain_ff, drain_in;
   logic [1:0] ek_ff, ek_in;
   logic [RW-1:0] nr1, nc1;

   // saturate size into 1..16, stored as count minus one
   assign nr1 = (rows_ff == '0) ? '0 : (rows_ff > 5'd16) ? 4'd15 : 4'(rows_ff - 1'b1);
   assign nc1 = (cols_ff == '0) ? '0 : (cols_ff > 5'd16) ? 4'd15 : 4'(cols_ff - 1'b1);

   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      r_in = r_ff;
      c_in = c_ff;
      drain_in = drain_ff;
      ek_in = ek_ff;
      cmd = '0;
      cmd.scan_addr = {r_ff, c_ff};
      cmd.emit_kind = ek_ff;
      cmd.emit_idx = r_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && final_in) begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.scan_start = 1'b1;
            r_in = '0;
            c_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (c_ff == nc1) begin
               c_in = '0;
               if (r_ff == nr1) begin
                  r_in = '0;
                  drain_in = 2'd0;
                  state_in = S_DRAIN;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // let the last reads land in the running best
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd1) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (sts.found) begin
               cmd.commit = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else begin
               ek_in = gsma_pkg::REC_ROW;
               r_in = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (ek_ff == gsma_pkg::REC_TOTAL) begin
               state_in = S_IDLE;
            end else if ((ek_ff == gsma_pkg::REC_ROW && r_ff == nr1)
                  || (ek_ff == gsma_pkg::REC_COL && r_ff == nc1)) begin
               r_in = '0;
               ek_in = ek_ff + 1'b1;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         r_ff <= '0;
         c_ff <= '0;
         drain_ff <= '0;
         ek_ff <= gsma_pkg::REC_ROW;
      end else begin
         state_ff <= state_in;
         r_ff <= r_in;
         c_ff <= c_in;
         drain_ff <= drain_in;
         ek_ff <= ek_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmd.emit && !cmd.commit)
      else $error("activity while idle");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == S_SCAN && r_ff == '0 && c_ff == '0)
      else $error("scan did not restart");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && ek_ff == gsma_pkg::REC_TOTAL) |=> state_ff == S_IDLE)
      else $error("totals record not last");
endmodule

// ===== verif/greedy_star_multi_assignment_tb.sv =====
`timescale 1ns / 100ps

module greedy_star_multi_assignment_tb;

   localparam int WATCH_LIMIT = 20000;

   typedef struct {
      logic [1:0]         kind;
      logic [3:0]         idx;
      logic [4:0]         gid;
      logic signed [20:0] total;
      logic [4:0]         count;
      logic               run_end;
   } mapping_rec_type;

   class assign_board;
      logic signed [15:0] costs [gsma_pkg::MAX_ROWS*gsma_pkg::MAX_COLS];
      int rows_used = 16;
      int cols_used = 16;
      mapping_rec_type want_q [$];
      int errors = 0;

      function void set_size(logic idx, logic [4:0] val);
         int v;
         v = (val < 1) ? 1 : val;
         if (idx == gsma_pkg::CSR_ROWS)
            rows_used = (v > gsma_pkg::MAX_ROWS) ? gsma_pkg::MAX_ROWS : v;
         else cols_used = (v > gsma_pkg::MAX_COLS) ? gsma_pkg::MAX_COLS : v;
      endfunction

      function void note_beat(logic [3:0] r, logic [3:0] c, logic signed [15:0] v,
                              logic fin);
         bit taken [gsma_pkg::MAX_ROWS*gsma_pkg::MAX_COLS];
         int row_grp [gsma_pkg::MAX_ROWS];
         int col_grp [gsma_pkg::MAX_COLS];
         logic [1:0] gkind [gsma_pkg::MAX_ROWS+1];
         int sum, made, br, bc, gr, gc, k;
         logic signed [15:0] bv;
         bit found, ok;
         mapping_rec_type rec;
         costs[r*gsma_pkg::MAX_COLS + c] = v;
         if (!fin) return;
         foreach (taken[n]) taken[n] = 0;
         foreach (row_grp[n]) row_grp[n] = 0;
         foreach (col_grp[n]) col_grp[n] = 0;
         foreach (gkind[n]) gkind[n] = gsma_pkg::KIND_NONE;
         sum = 0;
         made = 0;
         for (int n = 0; n < rows_used*cols_used; n++) begin
            found = 0;
            br = 0; bc = 0; bv = 0;
            // later entries win ties: larger row, then larger column
            for (int i = 0; i < rows_used; i++)
               for (int j = 0; j < cols_used; j++) begin
                  k = i*gsma_pkg::MAX_COLS + j;
                  if (!taken[k] && (!found || costs[k] >= bv)) begin
                     found = 1; bv = costs[k]; br = i; bc = j;
                  end
               end
            taken[br*gsma_pkg::MAX_COLS + bc] = 1;
            gr = row_grp[br];
            gc = col_grp[bc];
            ok = 0;
            if (gr != 0 && gc == 0) begin
               if (gkind[gr] == gsma_pkg::KIND_ONE || gkind[gr] == gsma_pkg::KIND_MCOL) begin
                  gkind[gr] = gsma_pkg::KIND_MCOL; col_grp[bc] = gr; ok = 1;
               end
            end else if (gr == 0 && gc != 0) begin
               if (gkind[gc] == gsma_pkg::KIND_ONE || gkind[gc] == gsma_pkg::KIND_MROW) begin
                  gkind[gc] = gsma_pkg::KIND_MROW; row_grp[br] = gc; ok = 1;
               end
            end else if (gr == 0 && gc == 0) begin
               made++;
               gkind[made] = gsma_pkg::KIND_ONE;
               row_grp[br] = made;
               col_grp[bc] = made;
               ok = 1;
            end
            if (ok) sum += bv;
         end
         rec.total = '0; rec.count = '0; rec.run_end = 1'b0;
         for (int i = 0; i < rows_used; i++) begin
            rec.kind = gsma_pkg::REC_ROW; rec.idx = 4'(i); rec.gid = 5'(row_grp[i]);
            want_q.insert(want_q.size(), rec);
         end
         for (int j = 0; j < cols_used; j++) begin
            rec.kind = gsma_pkg::REC_COL; rec.idx = 4'(j); rec.gid = 5'(col_grp[j]);
            want_q.insert(want_q.size(), rec);
         end
         rec.kind = gsma_pkg::REC_TOTAL; rec.idx = '0; rec.gid = '0;
         rec.total = 21'(sum); rec.count = 5'(made); rec.run_end = 1'b1;
         want_q.insert(want_q.size(), rec);
      endfunction

      function void cmp_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check(mapping_rec_type got);
         mapping_rec_type w;
         if (want_q.size() == 0) begin
            $display("%0t: unexpected record kind %0d idx %0d", $time, got.kind, got.idx);
            errors++;
            return;
         end
         w = want_q.pop_front();
         cmp_field("record_kind", w.kind, got.kind);
         cmp_field("map_index", w.idx, got.idx);
         cmp_field("group_id", w.gid, got.gid);
         cmp_field("total_cost", w.total, got.total);
         cmp_field("group_count", w.count, got.count);
         cmp_field("run_end", w.run_end, got.run_end);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [3:0] req_row_index = 0;
   logic [3:0] req_col_index = 0;
   logic signed [15:0] req_entry_cost = 0;
   logic req_final_entry = 0;
   logic rsp_valid;
   logic [1:0] rsp_record_kind;
   logic [3:0] rsp_map_index;
   logic [4:0] rsp_group_id;
   logic signed [20:0] rsp_total_cost;
   logic [4:0] rsp_group_count;
   logic rsp_run_end;
   logic csr_valid = 0;
   logic csr_ready;
   logic [0:0] csr_index = 0;
   logic [4:0] csr_data = 0;

   assign_board board = new();
   int idle_pct = 0;
   int quiet_cycles = 0;

   greedy_star_multi_assignment uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      mapping_rec_type got;
      if (!reset && rsp_valid) begin
         got.kind = rsp_record_kind; got.idx = rsp_map_index; got.gid = rsp_group_id;
         got.total = rsp_total_cost; got.count = rsp_group_count;
         got.run_end = rsp_run_end;
         board.check(got);
      end
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCH_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_entry(int r, int c, logic signed [15:0] v, bit fin);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_row_index <= 4'(r);
      req_col_index <= 4'(c);
      req_entry_cost <= v;
      req_final_entry <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_beat(4'(r), 4'(c), v, fin);
   endtask

   // hold until every record has come, then let the block settle
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (board.want_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_size(logic idx, logic [4:0] val);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      board.set_size(idx, val);
   endtask

   function automatic logic signed [15:0] pick_cost(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(6)) - 3);
         2: case ($urandom_range(3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         default: return 16'sh0100;
      endcase
   endfunction

   // write every active entry, plus a few stray ones outside, final flag last
   task automatic load_matrix(int mode);
      int nr, nc, strays, fr, fc;
      nr = board.rows_used;
      nc = board.cols_used;
      strays = (nr < gsma_pkg::MAX_ROWS) ? $urandom_range(2) : 0;
      for (int i = 0; i < nr; i++)
         for (int j = 0; j < nc; j++)
            if (!(strays == 0 && i == nr-1 && j == nc-1))
               send_entry(i, j, pick_cost(mode), 1'b0);
      if (strays == 0)
         send_entry(nr-1, nc-1, pick_cost(mode), 1'b1);
      else begin
         for (int s = 1; s < strays; s++)
            send_entry($urandom_range(gsma_pkg::MAX_ROWS-1, nr),
                       $urandom_range(gsma_pkg::MAX_COLS-1), pick_cost(0), 1'b0);
         fr = $urandom_range(gsma_pkg::MAX_ROWS-1, nr);
         fc = $urandom_range(gsma_pkg::MAX_COLS-1);
         send_entry(fr, fc, pick_cost(0), 1'b1);
      end
   endtask

   initial begin
      int sz;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single-entry matrix at both extremes of the cost range
      write_size(gsma_pkg::CSR_ROWS, 5'd1);
      write_size(gsma_pkg::CSR_COLS, 5'd1);
      send_entry(0, 0, 16'sh8000, 1'b1);
      send_entry(0, 0, 16'sh7fff, 1'b1);
      // out-of-range sizes saturate
      write_size(gsma_pkg::CSR_ROWS, 5'd0);
      write_size(gsma_pkg::CSR_COLS, 5'd31);
      load_matrix(2);
      write_size(gsma_pkg::CSR_ROWS, 5'd31);
      write_size(gsma_pkg::CSR_COLS, 5'd2);
      load_matrix(1);
      write_size(gsma_pkg::CSR_ROWS, 5'd3);
      load_matrix(3);
      send_entry(15, 15, -16'sd1, 1'b1);

      for (int run = 0; run < 8; run++) begin
         idle_pct = (run % 3 == 0) ? 0 : (run % 3 == 1) ? 54 : 30;
         sz = ($urandom_range(9) == 0) ? 5 : 3;
         write_size(gsma_pkg::CSR_ROWS, 5'($urandom_range(sz, 1)));
         write_size(gsma_pkg::CSR_COLS, 5'($urandom_range(sz, 1)));
         load_matrix($urandom_range(2));
         if (run % 5 == 4) drain();
      end
      drain();
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/gsma_pkg.sv
src/gsma_datapath.sv
src/gsma_ctrl.sv
src/greedy_star_multi_assignment.sv
verif/greedy_star_multi_assignment_tb.sv
